/* rtl/core/pivot_permutation_footrule_defines.svh */
// assertion macros for the pivot footrule block
`ifndef PIVOT_PERMUTATION_FOOTRULE_DEFINES_SVH
`define PIVOT_PERMUTATION_FOOTRULE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define PPF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/ppf_pkg.sv */
// shared constants and types of the pivot footrule block
package ppf_pkg;
    localparam int MAX_PIVOTS = 16;
    localparam int COORD_BITS = 12;
    localparam int IDX_BITS = $clog2(MAX_PIVOTS);
    localparam int CNT_BITS = $clog2(MAX_PIVOTS + 1);
    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam int SUM_BITS = 2 * IDX_BITS + 2;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_OBJECT = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    typedef struct packed {
        logic load_item;
        logic write_pivot;
        logic dist_step;
        logic rank_clear;
        logic rank_step;
        logic rank_store;
        logic sum_clear;
        logic sum_step;
        logic [IDX_BITS-1:0] p_idx;
        logic [IDX_BITS-1:0] q_idx;
    } ppf_cmd_t;
endpackage

/* rtl/core/ppf_ram.sv */
// generic single-port-write ram with registered read
module ppf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/ppf_datapath.sv */
// datapath: pivot memories, distance unit, rank counter and footrule sum
module ppf_datapath
    import ppf_pkg::*;
(
    input  logic                  clk,
    input  ppf_cmd_t              cmd,
    input  logic [1:0]            action,
    input  logic [IDX_BITS-1:0]   pivot_slot,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [7:0]            object_tag,
    output logic [7:0]            result_tag,
    output logic [7:0]            footrule_distance
);
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [7:0] tag_reg;
    logic [1:0] act_reg;
    logic [COORD_BITS-1:0] pvx, pvy;
    logic [DIST_BITS-1:0] dist_reg [MAX_PIVOTS];
    logic [IDX_BITS-1:0] rank_reg;
    logic [IDX_BITS-1:0] qrank;
    logic [SUM_BITS-1:0] sum_reg;
    logic [COORD_BITS-1:0] dx, dy;
    logic [DIST_BITS-1:0] dnew;
    logic [IDX_BITS-1:0] p_d;
    logic step_d, sum_d;
    logic [IDX_BITS-1:0] diff;
    logic is_query;
    // object rank kept per pivot in flops until summed
    logic [IDX_BITS-1:0] orank_reg [MAX_PIVOTS];

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            tag_reg <= object_tag;
            act_reg <= action;
        end
    end

    assign is_query = (act_reg == ACT_QUERY);

    ppf_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PIVOTS)) u_xram (
        .clk(clk), .we(cmd.write_pivot), .waddr(pivot_slot), .wdata(pos_x),
        .raddr(cmd.p_idx), .rdata(pvx));
    ppf_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PIVOTS)) u_yram (
        .clk(clk), .we(cmd.write_pivot), .waddr(pivot_slot), .wdata(pos_y),
        .raddr(cmd.p_idx), .rdata(pvy));
    ppf_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_PIVOTS)) u_qram (
        .clk(clk), .we(cmd.rank_store && is_query), .waddr(cmd.p_idx),
        .wdata(rank_reg), .raddr(cmd.p_idx), .rdata(qrank));

    // ram data arrives in the cycle after the address
    always_ff @(posedge clk)
    begin
        p_d    <= cmd.p_idx;
        step_d <= cmd.dist_step;
        sum_d  <= cmd.sum_step;
    end

    assign dx = (px_reg > pvx) ? px_reg - pvx : pvx - px_reg;
    assign dy = (py_reg > pvy) ? py_reg - pvy : pvy - py_reg;
    assign dnew = DIST_BITS'(dx * dx) + DIST_BITS'(dy * dy);

    always_ff @(posedge clk)
    begin
        if (step_d)
        begin
            dist_reg[p_d] <= dnew;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rank_clear)
        begin
            rank_reg <= '0;
        end
        else if (cmd.rank_step)
        begin
            if (dist_reg[cmd.q_idx] < dist_reg[cmd.p_idx] ||
                (dist_reg[cmd.q_idx] == dist_reg[cmd.p_idx] && cmd.q_idx < cmd.p_idx))
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rank_store)
        begin
            orank_reg[cmd.p_idx] <= rank_reg;
        end
    end

    assign diff = (orank_reg[p_d] > qrank) ? orank_reg[p_d] - qrank : qrank - orank_reg[p_d];

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clear)
        begin
            sum_reg <= '0;
        end
        else if (sum_d)
        begin
            sum_reg <= sum_reg + SUM_BITS'(diff);
        end
    end

    assign result_tag = tag_reg;
    assign footrule_distance = (sum_reg > SUM_BITS'(255)) ? 8'd255 : sum_reg[7:0];
endmodule

/* rtl/core/ppf_ctrl.sv */
// controller: sequences load, distance, ranking and footrule phases
module ppf_ctrl
    import ppf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          action,
    input  logic [CNT_BITS-1:0] count,
    output logic                busy,
    output logic                done,
    output ppf_cmd_t            cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIST = 7'b0000010,
        S_RANK = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_FLSH = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_BITS-1:0] p_reg, p_next, q_reg, q_next;
    logic obj_reg, obj_next;
    logic ready_reg, ready_next;
    logic [IDX_BITS-1:0] last;

    assign last = IDX_BITS'(count - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p_reg     <= '0;
            q_reg     <= '0;
            obj_reg   <= 1'b0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            obj_reg   <= obj_next;
            ready_reg <= ready_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        obj_next   = obj_reg;
        ready_next = ready_reg;
        cmd        = '0;
        cmd.p_idx  = p_reg;
        cmd.q_idx  = q_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    p_next = '0;
                    q_next = '0;
                    cmd.p_idx = '0;
                    if (action == ACT_LOAD)
                    begin
                        cmd.write_pivot = 1'b1;
                    end
                    else if (action == ACT_QUERY || (action == ACT_OBJECT && ready_reg))
                    begin
                        obj_next = (action == ACT_OBJECT);
                        if (action == ACT_QUERY)
                        begin
                            ready_next = 1'b1;
                        end
                        state_next = (count == '0) ? S_FLSH : S_DIST;
                        cmd.sum_clear = 1'b1;
                    end
                end
            end
            S_DIST:
            begin
                cmd.dist_step = 1'b1;
                if (p_reg == last)
                begin
                    p_next = '0;
                    state_next = S_FLSH;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            S_FLSH:
            begin
                // let the last distance land
                cmd.rank_clear = 1'b1;
                p_next = '0;
                q_next = '0;
                state_next = (count == '0) ? S_OUT : S_RANK;
            end
            S_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (q_reg == last)
                begin
                    q_next = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                end
            end
            S_SUM:
            begin
                cmd.rank_store = 1'b1;
                cmd.rank_clear = 1'b1;
                if (p_reg == last)
                begin
                    p_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_RANK;
                end
            end
            S_OUT:
            begin
                // object with pivots: sweep summation over pivots; otherwise finish and return to idle
                if (obj_reg && count != '0)
                begin
                    cmd.sum_step = 1'b1;
                    if (p_reg == last)
                    begin
                        p_next = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        p_next = p_reg + 1'b1;
                    end
                end
                else
                begin
                    done = obj_reg;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                // last ram read lands in the sum here
                done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

/* rtl/core/pivot_permutation_footrule.sv */
// top level of the pivot permutation footrule scorer
// a load ends at its accepting edge; a query steps through the distance, flush, rank and sum states;
// an object also runs the footrule sum and emit states, result strobed in the cycle busy falls
// one transaction at a time: start is taken only while idle, after the shared rank compare loop
// (n*n compares, one per cycle while in the rank state) and the n-step footrule sum
// reset: asynchronous, clears controller, count_reg and query-valid flag; no stall
module pivot_permutation_footrule
    import ppf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            action,
    input  logic [3:0]            pivot_slot,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [7:0]            object_tag,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [4:0]            cfg_data,
    output logic                  result_valid,
    output logic [7:0]            result_tag,
    output logic [7:0]            footrule_distance
);
`include "pivot_permutation_footrule_defines.svh"
    logic [4:0] count_reg;
    logic [CNT_BITS-1:0] count;
    ppf_cmd_t cmd;
    logic done;

    assign cfg_ready = !busy;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end
    assign count = (count_reg > 5'(MAX_PIVOTS)) ? CNT_BITS'(MAX_PIVOTS) : CNT_BITS'(count_reg);

    ppf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action), .count(count),
        .busy(busy), .done(done), .cmd(cmd));

    ppf_datapath u_dp (
        .clk(clk), .cmd(cmd), .action(action), .pivot_slot(pivot_slot[IDX_BITS-1:0]),
        .pos_x(pos_x), .pos_y(pos_y), .object_tag(object_tag),
        .result_tag(result_tag), .footrule_distance(footrule_distance));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= done;
        end
    end

    `PPF_ASSERT_IMP(a_idle_at_result, result_valid, !busy)
    `PPF_ASSERT_NXT(a_busy_after_work, start && !busy && action == ACT_QUERY, busy)
    `PPF_ASSERT_NXT(a_single_strobe, result_valid, !result_valid)
endmodule
